// ===== sv/ecal_pkg.sv =====
// Shared constants, types and the month table for the epoch-to-calendar converter.
`timescale 1ns / 1ps

package ecal_pkg;

    // Field widths
    localparam int SEC_W  = 32;
    localparam int STAGES = 9;

    // Calendar constants (day 0 of the shifted count is 0000-03-01)
    localparam logic [15:0] ERA5_DAY   = 16'd11017;   // first epoch day of era 5
    localparam logic [17:0] ERA4_SHIFT = 18'd135080;  // epoch day to day of era 4
    localparam logic [17:0] ERA_LAST   = 18'd146096;
    localparam logic [17:0] CENT_DAYS  = 18'd36524;
    localparam logic [15:0] WDAY_SHIFT = 16'd4;
    localparam logic [9:0]  DAY_HI_DIV = 10'd675;     // 86400 / 128
    localparam logic [11:0] SECS_HOUR  = 12'd3600;
    localparam logic [6:0]  SECS_MIN   = 7'd60;
    localparam logic [8:0]  MAR_DEC    = 9'd306;
    localparam logic [8:0]  JAN_FEB    = 9'd59;

    // Round-up reciprocals: floor(x / d) == (x * M) >> K for the listed x range
    localparam logic [25:0] M_DAY  = 26'd50903317;  // x < 2^25, d = 675, K = 35
    localparam logic [13:0] M_HOUR = 14'd9321;      // x < 2^13, d = 225, K = 21
    localparam logic [10:0] M_MIN  = 11'd1093;      // x < 2^10, d = 15,  K = 14
    localparam logic [16:0] M_WEEK = 17'd74899;     // x < 2^16, d = 7,   K = 19
    localparam logic [16:0] M_QUAD = 17'd91930;     // x < 2^16, d = 365, K = 25
    localparam logic [18:0] M_YEAR = 19'd367720;    // x < 2^18, d = 365, K = 27
    localparam logic [9:0]  M_CENT = 10'd656;       // x < 2^9,  d = 100, K = 16
    localparam logic [11:0] M_MON  = 12'd3427;      // x < 2^11, d = 153, K = 19

    // Pipeline control between flow unit and datapath
    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
    } t_flow;

    // First March-based day of each month, (153 * m + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/ecal_in_if.sv =====
// Input channel: one epoch timestamp per transfer.
`timescale 1ns / 1ps

interface ecal_in_if;
    logic                       valid;
    logic                       ready;
    logic [ecal_pkg::SEC_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== sv/ecal_out_if.sv =====
// Output channel: one broken-down UTC date and time per transfer.
`timescale 1ns / 1ps

interface ecal_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;

    modport source (output valid, output second, output minute, output hour,
                    output weekday, output day_of_year, output years_since_1900,
                    output month_index, output day_of_month, input ready);
    modport sink   (input valid, input second, input minute, input hour,
                    input weekday, input day_of_year, input years_since_1900,
                    input month_index, input day_of_month, output ready);
endinterface

// ===== sv/epoch_seconds_to_calendar.sv =====
// Top level: nine-stage converter from epoch seconds to UTC calendar fields.
// Throughput: one timestamp per cycle unless the output stalls a full pipe; each stage
// holds only a few constant multiplies side by side, so a new item may enter every cycle.
// Empty stages fill while the output is stalled; a full pipe holds in place.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ecal_in_if.sink       i_in,
    ecal_out_if.source    o_out
);

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] d;        // days since 1970-01-01
        logic [9:0]  sod_hi;   // seconds of day / 128
        logic [6:0]  lo7;
        logic        era5;
        logic [17:0] eday;
        logic [15:0] wdx;
        logic [4:0]  hour;
        logic [6:0]  a;
        logic [2:0]  b;
        logic        c;
        logic [12:0] wq;
        logic [17:0] n;
        logic [11:0] mrem;
        logic [2:0]  wd;
        logic [8:0]  eyear;
        logic [5:0]  minute;
        logic [1:0]  e100;
        logic [17:0] ybase;
        logic [5:0]  second;
        logic [8:0]  yday;
        logic        leap;
        logic [3:0]  mon0;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [8:0]  doy;
        logic [7:0]  ys;
    } t_pipe;

    ecal_pkg::t_flow ctl;
    t_pipe           r_p [ecal_pkg::STAGES];
    t_pipe           n_p [ecal_pkg::STAGES];

    ecal_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_ctl       (ctl)
    );

    assign i_in.ready = ctl.load[0];

    // Stage 0: day count = t / 86400 = (t >> 7) / 675
    always_comb begin
        logic [50:0] p;
        n_p[0]   = '0;
        n_p[0].t = i_in.epoch_seconds;
        p        = 51'(i_in.epoch_seconds[31:7]) * 51'(ecal_pkg::M_DAY);
        n_p[0].d = p[50:35];
    end

    // Stage 1: seconds of day, era select, day of era, weekday operand
    always_comb begin
        logic [24:0] x;
        x             = r_p[0].t[31:7];
        n_p[1]        = r_p[0];
        n_p[1].sod_hi = 10'(x - 25'(r_p[0].d) * 25'(ecal_pkg::DAY_HI_DIV));
        n_p[1].lo7    = r_p[0].t[6:0];
        n_p[1].era5   = r_p[0].d >= ecal_pkg::ERA5_DAY;
        n_p[1].eday   = (r_p[0].d >= ecal_pkg::ERA5_DAY)
                      ? 18'(r_p[0].d) - 18'(ecal_pkg::ERA5_DAY)
                      : 18'(r_p[0].d) + ecal_pkg::ERA4_SHIFT;
        n_p[1].wdx    = r_p[0].d + ecal_pkg::WDAY_SHIFT;
    end

    // Stage 2: hour, leap-day corrections, weekday quotient
    always_comb begin
        logic [26:0] ph;
        logic [32:0] pq;
        logic [32:0] pw;
        n_p[2]      = r_p[1];
        ph          = 27'({r_p[1].sod_hi, r_p[1].lo7[6:4]}) * 27'(ecal_pkg::M_HOUR);
        n_p[2].hour = ph[25:21];
        pq          = 33'(r_p[1].eday[17:2]) * 33'(ecal_pkg::M_QUAD);
        n_p[2].a    = pq[31:25];
        n_p[2].b    = 3'(r_p[1].eday >= ecal_pkg::CENT_DAYS)
                    + 3'(r_p[1].eday >= 18'(2 * 36524))
                    + 3'(r_p[1].eday >= 18'(3 * 36524))
                    + 3'(r_p[1].eday >= 18'(4 * 36524));
        n_p[2].c    = r_p[1].eday == ecal_pkg::ERA_LAST;
        pw          = 33'(r_p[1].wdx) * 33'(ecal_pkg::M_WEEK);
        n_p[2].wq   = pw[31:19];
    end

    // Stage 3: year numerator, seconds within hour, weekday
    always_comb begin
        logic [16:0] sod;
        sod         = {r_p[2].sod_hi, r_p[2].lo7};
        n_p[3]      = r_p[2];
        n_p[3].n    = r_p[2].eday - 18'(r_p[2].a) + 18'(r_p[2].b) - 18'(r_p[2].c);
        n_p[3].mrem = 12'(sod - 17'(r_p[2].hour) * 17'(ecal_pkg::SECS_HOUR));
        n_p[3].wd   = 3'(r_p[2].wdx - 16'(r_p[2].wq) * 16'd7);
    end

    // Stage 4: year of era, minute
    always_comb begin
        logic [36:0] py;
        logic [20:0] pm;
        n_p[4]        = r_p[3];
        py            = 37'(r_p[3].n) * 37'(ecal_pkg::M_YEAR);
        n_p[4].eyear  = py[35:27];
        pm            = 21'(r_p[3].mrem[11:2]) * 21'(ecal_pkg::M_MIN);
        n_p[4].minute = pm[19:14];
    end

    // Stage 5: century count, start of year within era, second
    always_comb begin
        logic [18:0] pc;
        n_p[5]        = r_p[4];
        pc            = 19'(r_p[4].eyear) * 19'(ecal_pkg::M_CENT);
        n_p[5].e100   = pc[17:16];
        n_p[5].ybase  = 18'(r_p[4].eyear) * 18'd365 + 18'(r_p[4].eyear[8:2]);
        n_p[5].second = 6'(r_p[4].mrem
                      - 12'(r_p[4].minute) * 12'(ecal_pkg::SECS_MIN));
    end

    // Stage 6: March-based day of year, leap flag of the era year
    always_comb begin
        n_p[6]      = r_p[5];
        n_p[6].yday = 9'(r_p[5].eday - r_p[5].ybase + 18'(r_p[5].e100));
        n_p[6].leap = ((r_p[5].eyear[1:0] == 2'd0)
                       && (r_p[5].eyear != 9'(r_p[5].e100) * 9'd100))
                    || (r_p[5].eyear == 9'd0);
    end

    // Stage 7: March-based month
    always_comb begin
        logic [10:0] num;
        logic [22:0] pmo;
        n_p[7]      = r_p[6];
        num         = 11'(r_p[6].yday) * 11'd5 + 11'd2;
        pmo         = 23'(num) * 23'(ecal_pkg::M_MON);
        n_p[7].mon0 = pmo[22:19];
    end

    // Stage 8: calendar month, day of month, year, day of year
    always_comb begin
        logic jan;
        jan          = r_p[7].mon0 >= 4'd10;
        n_p[8]       = r_p[7];
        n_p[8].month = jan ? r_p[7].mon0 - 4'd10 : r_p[7].mon0 + 4'd2;
        n_p[8].mday  = 5'(r_p[7].yday - ecal_pkg::month_start(r_p[7].mon0) + 9'd1);
        n_p[8].ys    = r_p[7].era5
                     ? 8'(10'(r_p[7].eyear) + 10'd100 + 10'(jan))
                     : 8'(10'(r_p[7].eyear) - 10'd300 + 10'(jan));
        n_p[8].doy   = (r_p[7].yday >= ecal_pkg::MAR_DEC)
                     ? r_p[7].yday - ecal_pkg::MAR_DEC
                     : r_p[7].yday + ecal_pkg::JAN_FEB + 9'(r_p[7].leap);
    end

    // Stage registers
    for (genvar g = 0; g < ecal_pkg::STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (ctl.load[g]) begin
                r_p[g] <= n_p[g];
            end
        end
    end

    // Result transfer
    assign o_out.valid            = ctl.valid[ecal_pkg::STAGES-1];
    assign o_out.second           = r_p[ecal_pkg::STAGES-1].second;
    assign o_out.minute           = r_p[ecal_pkg::STAGES-1].minute;
    assign o_out.hour             = r_p[ecal_pkg::STAGES-1].hour;
    assign o_out.weekday          = r_p[ecal_pkg::STAGES-1].wd;
    assign o_out.day_of_year      = r_p[ecal_pkg::STAGES-1].doy;
    assign o_out.years_since_1900 = r_p[ecal_pkg::STAGES-1].ys;
    assign o_out.month_index      = r_p[ecal_pkg::STAGES-1].month;
    assign o_out.day_of_month     = r_p[ecal_pkg::STAGES-1].mday;

`ifndef SYNTHESIS
    // Input only backs up when the output is holding a result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output back-pressure");

    // An accepted timestamp occupies the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> ctl.valid[0])
        else $error("accepted item lost at pipeline entry");

    // Time-of-day and weekday fields stay in range
    a_time_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hour < 5'd24 && o_out.minute < 6'd60
                         && o_out.second < 6'd60 && o_out.weekday < 3'd7))
        else $error("time-of-day field out of range");

    // Date fields stay in range
    a_date_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month_index < 4'd12 && o_out.day_of_month != 5'd0
                         && o_out.day_of_year < 9'd366
                         && o_out.years_since_1900 >= 8'd70
                         && o_out.years_since_1900 <= 8'd206))
        else $error("date field out of range");
`endif

endmodule

// ===== sv/ecal_flow.sv =====
// Valid tracking and per-stage load enables for the converter pipeline.
`timescale 1ns / 1ps

module ecal_flow (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    output ecal_pkg::t_flow o_ctl
);

    logic [ecal_pkg::STAGES-1:0] r_vld;
    logic [ecal_pkg::STAGES-1:0] n_vld;
    logic [ecal_pkg::STAGES-1:0] rdy;

    // A stage loads when it is empty or its content moves on; bubbles collapse
    always_comb begin
        rdy[ecal_pkg::STAGES-1] = !r_vld[ecal_pkg::STAGES-1] || i_out_ready;
        for (int i = ecal_pkg::STAGES - 2; i >= 0; i--) begin
            rdy[i] = !r_vld[i] || rdy[i+1];
        end
    end

    // Valid bits follow the data
    always_comb begin
        n_vld[0] = i_in_valid;
        for (int i = 1; i < ecal_pkg::STAGES; i++) begin
            n_vld[i] = r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < ecal_pkg::STAGES; i++) begin
                if (rdy[i]) begin
                    r_vld[i] <= n_vld[i];
                end
            end
        end
    end

    assign o_ctl.load  = rdy;
    assign o_ctl.valid = r_vld;

endmodule
